>>> rtl/mbps_pkg.sv
`timescale 1ns / 1ps

package mbps_pkg;

	// Fixed field widths of the block.
	localparam int ADDR_W      = 64;
	localparam int COUNT_W     = 32;
	localparam int LEN_W       = 5;
	localparam int PAT_SLOTS   = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;

	// Defaults for the top-level parameters.
	localparam int PATTERN_MAX_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REPORT_ALL     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS   = 3'd5;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [8*PAT_SLOTS-1:0] pattern;
		logic [PAT_SLOTS-1:0]   care_mask;
		logic [LEN_W-1:0]       pattern_length;
		logic                   report_all;
		logic [ADDR_W-1:0]      base_address;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic               match_valid;
		logic [ADDR_W-1:0]  match_address;
		logic               region_end;
		logic [COUNT_W-1:0] match_count;
		logic               offset_saturated;
	} res_t;

endpackage

>>> rtl/mbps_if.sv
`timescale 1ns / 1ps

// Byte stream into the scanner.
interface mbps_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

// Result items out of the scanner.
interface mbps_result_if;
	logic        valid;
	logic        ready;
	logic        match_valid;
	logic [63:0] match_address;
	logic        region_end;
	logic [31:0] match_count;
	logic        offset_saturated;

	modport source(output valid, match_valid, match_address, region_end, match_count,
		offset_saturated, input ready);
	modport sink(input valid, match_valid, match_address, region_end, match_count,
		offset_saturated, output ready);
endinterface

>>> rtl/mbps_cfg.sv
`timescale 1ns / 1ps

module mbps_cfg
	import mbps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Register file; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern        <= '0;
			cfg_q.care_mask      <= '1;
			cfg_q.pattern_length <= LEN_W'(1);
			cfg_q.report_all     <= 1'b0;
			cfg_q.base_address   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:    cfg_q.pattern[63:0]   <= cfg_data;
				REG_PATTERN_HIGH:   cfg_q.pattern[127:64] <= cfg_data;
				REG_CARE_MASK:      cfg_q.care_mask      <= cfg_data[PAT_SLOTS-1:0];
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data[LEN_W-1:0];
				REG_REPORT_ALL:     cfg_q.report_all     <= cfg_data[0];
				REG_BASE_ADDRESS:   cfg_q.base_address   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/mbps_match.sv
`timescale 1ns / 1ps

module mbps_match
	import mbps_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   shift_en,
	input  logic [7:0]             cur_byte,
	input  cfg_t                   cfg,
	input  logic [OFFSET_BITS-1:0] offset,
	output logic                   hit,
	output logic [ADDR_W-1:0]      match_address
);

	localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

	logic [7:0]       win_q [WIN_DEPTH];
	logic [7:0]       aged [PATTERN_MAX];
	logic [7:0]       seen [PATTERN_MAX];
	logic [LEN_W-1:0] len_used;
	logic [LEN_W-1:0] len_m1;
	logic             bytes_ok;
	logic             enough;

	// Sliding window of earlier bytes, most recent in entry 0. Entries that were
	// never written since the region start are never compared, so no clear is needed.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q[0] <= cur_byte;
			for (int j = 1; j < WIN_DEPTH; j++) begin
				win_q[j] <= win_q[j-1];
			end
		end
	end

	// Effective pattern length: zero counts as one, above the maximum is clipped.
	always_comb begin
		if (cfg.pattern_length == '0) begin
			len_used = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(PATTERN_MAX)) begin
			len_used = LEN_W'(PATTERN_MAX);
		end else begin
			len_used = cfg.pattern_length;
		end
		len_m1 = len_used - LEN_W'(1);
	end

	// Bytes by age: age zero is the current byte.
	always_comb begin
		aged[0] = cur_byte;
		for (int a = 1; a < PATTERN_MAX; a++) begin
			aged[a] = win_q[a-1];
		end
	end

	// Pattern byte k lines up with the byte of age len-1-k.
	always_comb begin
		bytes_ok = 1'b1;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			seen[k] = '0;
			for (int a = 0; a < PATTERN_MAX; a++) begin
				if (LEN_W'(a) == len_m1 - LEN_W'(k)) begin
					seen[k] = aged[a];
				end
			end
			if (LEN_W'(k) < len_used && cfg.care_mask[k] &&
				seen[k] != cfg.pattern[8*k +: 8]) begin
				bytes_ok = 1'b0;
			end
		end
	end

	// A start position before the region's first byte never matches.
	assign enough = offset >= OFFSET_BITS'(len_m1);
	assign hit    = bytes_ok && enough;

	assign match_address = cfg.base_address + ADDR_W'(offset - OFFSET_BITS'(len_m1));

endmodule

>>> rtl/mbps_result.sv
`timescale 1ns / 1ps

module mbps_result
	import mbps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_d,
	input  logic out_ready,
	output logic can_take,
	output logic out_valid,
	output res_t res
);

	logic valid_q;
	res_t res_q;

	// The register can take a new result when empty or when its item leaves now.
	assign can_take = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign res       = res_q;

endmodule

>>> rtl/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps

// Masked byte pattern scanner. Bytes of a memory region arrive on the stream
// channel, one transfer per byte, with last_byte set on the region's final byte.
// After each byte the block checks whether the configured pattern (up to
// PATTERN_MAX bytes, each position either compared or a wildcard per care_mask)
// ends at that byte, overlaps included. A result transfer is produced for a
// reported match (every match with report_all set, else only the first of the
// region) and always for the last byte, which carries region_end and the count.
// Throughput is one byte per clock: the window compare and the address add sit
// between the input handshake and a single result register, so a result shows
// in the cycle after its byte is taken, and the stream stalls only while a result
// waits in that register and the result channel is not ready. The offset
// counter is OFFSET_BITS wide and saturates; offset_saturated flags bytes seen
// after it filled. Write configuration only while no byte is in flight.
module masked_byte_pattern_scanner
	import mbps_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	mbps_stream_if.sink            stream,
	mbps_result_if.source          result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                   cfg;
	logic                   stream_xfer;
	logic                   can_take;
	logic                   hit;
	logic                   rpt;
	logic                   emit;
	logic [ADDR_W-1:0]      hit_address;
	logic [OFFSET_BITS-1:0] off_q;
	logic                   overflow_q;
	logic [COUNT_W-1:0]     count_q;
	logic [COUNT_W-1:0]     count_next;
	logic                   first_q;
	res_t                   res_d;
	res_t                   res;
	logic                   out_valid;

	mbps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbps_match #(
		.PATTERN_MAX (PATTERN_MAX),
		.OFFSET_BITS (OFFSET_BITS)
	) u_match (
		.clk           (clk),
		.shift_en      (stream_xfer),
		.cur_byte      (stream.data_byte),
		.cfg           (cfg),
		.offset        (off_q),
		.hit           (hit),
		.match_address (hit_address)
	);

	// Input handshake.
	assign stream.ready = can_take;
	assign stream_xfer  = stream.valid && can_take;

	// Report decision and the count including this match.
	assign rpt        = hit && (cfg.report_all || !first_q);
	assign count_next = (rpt && count_q != '1) ? count_q + COUNT_W'(1) : count_q;
	assign emit       = stream_xfer && (rpt || stream.last_byte);

	// Scan state of the current region; the last byte restarts it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q      <= '0;
			overflow_q <= 1'b0;
			count_q    <= '0;
			first_q    <= 1'b0;
		end else if (stream_xfer) begin
			if (stream.last_byte) begin
				off_q      <= '0;
				overflow_q <= 1'b0;
				count_q    <= '0;
				first_q    <= 1'b0;
			end else begin
				count_q <= count_next;
				if (rpt) begin
					first_q <= 1'b1;
				end
				if (off_q == '1) begin
					overflow_q <= 1'b1;
				end else begin
					off_q <= off_q + OFFSET_BITS'(1);
				end
			end
		end
	end

	// Result item built from this byte.
	always_comb begin
		res_d.match_valid      = rpt;
		res_d.match_address    = rpt ? hit_address : '0;
		res_d.region_end       = stream.last_byte;
		res_d.match_count      = count_next;
		res_d.offset_saturated = overflow_q;
	end

	mbps_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit),
		.res_d     (res_d),
		.out_ready (result.ready),
		.can_take  (can_take),
		.out_valid (out_valid),
		.res       (res)
	);

	assign result.valid            = out_valid;
	assign result.match_valid      = res.match_valid;
	assign result.match_address    = res.match_address;
	assign result.region_end       = res.region_end;
	assign result.match_count      = res.match_count;
	assign result.offset_saturated = res.offset_saturated;

`ifndef ASSERT_OFF
	// The overflow flag is only ever set with the offset counter at its top.
	a_overflow_at_top: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> (off_q == '1))
		else $error("overflow flag set with offset below top");

	// The last byte of a region restarts the offset and the match count.
	a_region_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(stream_xfer && stream.last_byte) |=> (off_q == '0 && count_q == '0 && !first_q))
		else $error("scan state not restarted after region end");

	// A byte that causes a result leaves it waiting in the result register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> result.valid)
		else $error("result lost after an accepted byte");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import mbps_pkg::*;

	// The offset counter is built at a reduced width of 16 bits.
	localparam int SCAN_OFFSET_BITS = 16;
	localparam logic [63:0] OFFSET_TOP = (64'd1 << SCAN_OFFSET_BITS) - 64'd1;
	localparam int SETTLE_CYCLES = 4;
	localparam int RUN_LIMIT = 1000000;
	localparam int ERROR_PRINT_MAX = 40;
	localparam int RANDOM_PHASES = 12;
	localparam int BYTES_PER_PHASE = 90;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} region_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	mbps_stream_if stream_ch();
	mbps_result_if result_ch();

	masked_byte_pattern_scanner #(
		.PATTERN_MAX(PATTERN_MAX_DEF),
		.OFFSET_BITS(SCAN_OFFSET_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register contents as the scanner should hold them.
	logic [63:0] pattern_lo_cfg = '0;
	logic [63:0] pattern_hi_cfg = '0;
	logic [15:0] care_cfg = 16'hFFFF;
	logic [4:0]  length_cfg = 5'd1;
	logic        report_all_cfg = 1'b0;
	logic [63:0] base_cfg = '0;

	// Scan state of the current region.
	logic [7:0]  recent_bytes [0:14];
	logic [63:0] next_offset = '0;
	logic [31:0] region_matches = '0;
	logic        first_reported = 1'b0;
	logic        offset_full = 1'b0;

	region_byte_t bytes_to_send [$];
	res_t         pending_reports [$];
	logic [7:0]   region_buf [$];
	int unsigned  bytes_unaccepted = 0;
	int unsigned  mismatches = 0;
	int unsigned  cycle_count;

	// Idling control for both channels.
	logic        idle_on = 1'b1;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int unsigned stall_step = 0;

	initial begin
		for (int i = 0; i < 15; i++) recent_bytes[i] = '0;
	end

	function automatic int unsigned used_length();
		int unsigned n;
		n = (length_cfg == 0) ? 1 : length_cfg;
		if (n > PATTERN_MAX_DEF) n = PATTERN_MAX_DEF;
		return n;
	endfunction

	function automatic void restart_region();
		int unsigned k;
		for (k = 0; k < 15; k++) recent_bytes[k] = '0;
		next_offset = '0;
		region_matches = '0;
		first_reported = 1'b0;
		offset_full = 1'b0;
	endfunction

	// Works out the result, if any, that one accepted byte causes and updates the scan state.
	function automatic void scan_byte(input logic [7:0] cur, input logic last);
		int unsigned n;
		int unsigned k;
		logic [127:0] pat;
		logic [7:0] seen;
		logic [63:0] off;
		logic hit;
		logic report;
		res_t r;
		n = used_length();
		pat = {pattern_hi_cfg, pattern_lo_cfg};
		off = next_offset;
		// A start position before the region's first byte never matches.
		hit = (off >= n - 1);
		for (k = 0; k < n; k++) begin
			if (k == n - 1) seen = cur;
			else seen = recent_bytes[n - 2 - k];
			if (care_cfg[k] && seen != pat[8*k +: 8]) hit = 1'b0;
		end
		report = hit && (report_all_cfg || !first_reported);
		r = '0;
		if (report) begin
			first_reported = 1'b1;
			if (region_matches != '1) region_matches = region_matches + 1;
			r.match_valid = 1'b1;
			r.match_address = base_cfg + off - 64'(n - 1);
		end
		r.region_end = last;
		r.match_count = region_matches;
		r.offset_saturated = offset_full;
		for (k = 14; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
		recent_bytes[0] = cur;
		// The offset sticks at its top value once a byte there has been taken.
		if (off >= OFFSET_TOP) begin
			next_offset = OFFSET_TOP;
			offset_full = 1'b1;
		end else begin
			next_offset = off + 1;
		end
		if (report || last) pending_reports = {pending_reports, r};
		if (last) restart_region();
	endfunction

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= ERROR_PRINT_MAX) $error("%s", msg);
	endfunction

	function automatic void compare_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want)
			note_failure($sformatf("%s: expected 0x%0h, got 0x%0h", field, want, got));
	endfunction

	function automatic void check_result();
		res_t want;
		if (pending_reports.size() == 0) begin
			note_failure($sformatf("result transfer with nothing expected: match_valid %0b address 0x%0h",
				result_ch.match_valid, result_ch.match_address));
			return;
		end
		want = pending_reports.pop_front();
		compare_field("match_valid", 64'(want.match_valid), 64'(result_ch.match_valid));
		compare_field("match_address", want.match_address, result_ch.match_address);
		compare_field("region_end", 64'(want.region_end), 64'(result_ch.region_end));
		compare_field("match_count", 64'(want.match_count), 64'(result_ch.match_count));
		compare_field("offset_saturated", 64'(want.offset_saturated),
			64'(result_ch.offset_saturated));
	endfunction

	// Byte driver: bursts of transfers separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			stream_ch.valid <= 1'b0;
			stream_ch.data_byte <= '0;
			stream_ch.last_byte <= 1'b0;
		end else begin
			if (stream_ch.valid && stream_ch.ready) begin
				scan_byte(stream_ch.data_byte, stream_ch.last_byte);
				bytes_unaccepted--;
			end
			if (!stream_ch.valid || stream_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					stream_ch.valid <= 1'b0;
				end else if (bytes_to_send.size() != 0) begin
					stream_ch.valid <= 1'b1;
					stream_ch.data_byte <= bytes_to_send[0].data;
					stream_ch.last_byte <= bytes_to_send[0].last;
					void'(bytes_to_send.pop_front());
					if (idle_on) begin
						if (burst_left <= 1) begin
							burst_left = $urandom_range(1, 24);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
						end else begin
							burst_left--;
						end
					end
				end else begin
					stream_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transfer and stalls on a rotating ready pattern.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) check_result();
			result_ch.ready <= idle_on ? ready_pattern[stall_step] : 1'b1;
			stall_step = (stall_step + 1) % 16;
			if (stall_step == 0)
				ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_PATTERN_LOW: pattern_lo_cfg = value;
			REG_PATTERN_HIGH: pattern_hi_cfg = value;
			REG_CARE_MASK: care_cfg = value[15:0];
			REG_PATTERN_LENGTH: length_cfg = value[4:0];
			REG_REPORT_ALL: report_all_cfg = value[0];
			REG_BASE_ADDRESS: base_cfg = value;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every byte is taken and every result has come, then lets the pipe drain.
	task automatic wait_idle();
		while (bytes_unaccepted != 0 || pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Queues the buffered region, with the last byte marked.
	function automatic void send_region();
		int unsigned i;
		region_byte_t b;
		for (i = 0; i < region_buf.size(); i++) begin
			b.data = region_buf[i];
			b.last = (i == region_buf.size() - 1);
			bytes_to_send = {bytes_to_send, b};
		end
		bytes_unaccepted += region_buf.size();
		region_buf.delete();
	endfunction

	function automatic void place_pattern(input int unsigned start);
		int unsigned j;
		logic [127:0] pat;
		pat = {pattern_hi_cfg, pattern_lo_cfg};
		for (j = 0; j < used_length() && start + j < region_buf.size(); j++)
			region_buf[start + j] = pat[8*j +: 8];
	endfunction

	// Random bytes drawn half from the pattern, with up to three copies of it planted, cut short at the region's end.
	function automatic void build_random_region(input int unsigned len);
		int unsigned i;
		logic [127:0] pat;
		pat = {pattern_hi_cfg, pattern_lo_cfg};
		region_buf.delete();
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 1) == 0) region_buf = {region_buf, 8'($urandom)};
			else region_buf = {region_buf, pat[8*$urandom_range(0, 15) +: 8]};
		end
		repeat ($urandom_range(0, 3)) place_pattern($urandom_range(0, len - 1));
	endfunction

	task automatic random_config();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] value;
		int unsigned style;
		style = $urandom_range(0, 3);
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		// Repetitive patterns give plenty of overlapping matches.
		if (style == 0) begin
			lo = {8{lo[7:0]}};
			hi = lo;
		end else if (style == 1) begin
			lo = {4{lo[15:0]}};
			hi = lo;
		end
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		value = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: value[15:0] = 16'hFFFF;
			1: value[15:0] = 16'h0000;
			default: ;
		endcase
		write_reg(REG_CARE_MASK, value);
		value = {$urandom, $urandom};
		value[4:0] = ($urandom_range(0, 2) != 0) ? 5'($urandom_range(1, 6))
			: 5'($urandom_range(0, 31));
		write_reg(REG_PATTERN_LENGTH, value);
		write_reg(REG_REPORT_ALL, {$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: value = '0;
			1: value = '1;
			default: value = {$urandom, $urandom};
		endcase
		write_reg(REG_BASE_ADDRESS, value);
		if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
		end_writes();
	endtask

	// Watchdog on the whole run.
	initial begin
		for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int unsigned phase_bytes;
		int unsigned len;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings, first-only mode: later hits are not reported, end without a match.
		region_buf = '{8'h00, 8'h00, 8'hFF, 8'h00};
		send_region();
		region_buf = '{8'hFF};
		send_region();
		wait_idle();

		// Length zero acts as one, all wildcards, base address wraps around.
		write_reg(REG_CARE_MASK, 64'h0);
		write_reg(REG_PATTERN_LENGTH, 64'h0);
		write_reg(REG_REPORT_ALL, 64'h1);
		write_reg(REG_BASE_ADDRESS, '1);
		end_writes();
		region_buf = '{8'h00, 8'hFF};
		send_region();
		wait_idle();

		// Oversized length saturates; a full pattern matches exactly on the last byte.
		write_reg(REG_PATTERN_LOW, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_PATTERN_HIGH, 64'hFF00_A55A_3CC3_F00F);
		write_reg(REG_CARE_MASK, 64'hFFFF);
		write_reg(REG_PATTERN_LENGTH, 64'd31);
		write_reg(REG_REPORT_ALL, 64'h0);
		write_reg(REG_BASE_ADDRESS, 64'h0000_0000_1000_0000);
		end_writes();
		region_buf.delete();
		for (int i = 0; i < 16; i++) region_buf = {region_buf, 8'h00};
		place_pattern(0);
		send_region();
		wait_idle();

		// Only the two final positions compared: a region too short must not match.
		write_reg(REG_CARE_MASK, 64'hC000);
		end_writes();
		region_buf = '{8'h00, 8'hFF};
		send_region();
		wait_idle();

		// Random settings, each followed by a batch of random regions.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_config();
			idle_on = (p != RANDOM_PHASES / 2);
			phase_bytes = 0;
			while (phase_bytes < BYTES_PER_PHASE) begin
				case ($urandom_range(0, 19))
					0: len = 1;
					1, 2, 3: len = $urandom_range(25, 80);
					default: len = $urandom_range(1, 24);
				endcase
				build_random_region(len);
				send_region();
				phase_bytes += len;
			end
			wait_idle();
		end

		repeat (16) @(posedge clk);
		if (mismatches == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
